// ===== design/nct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_pkg
// shared types and codes of the nat connection table
// ----------------------------------------------------------------------------
package nct_pkg;

  localparam logic [1:0] FUNC_INBOUND  = 2'd0;
  localparam logic [1:0] FUNC_OUTBOUND = 2'd1;
  localparam logic [1:0] FUNC_CLEAN    = 2'd2;
  // spare code, leaves the table alone and returns an all-zero result
  localparam logic [1:0] FUNC_NOP      = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_BUCKET = 2'd1;
  localparam logic [1:0] ST_NO_ENTRY  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic CFG_GATEWAY_IP = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
  localparam logic [6:0]  REMOVED_MAX   = 7'd127;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  // query held steady while a token runs down the chain
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  proto;
    logic [31:0] key;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [31:0] now_ms;
  } query_t;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        bucket;
    logic        hit;
    logic        free_found;
    logic [6:0]  removed;
    logic [31:0] res_ip;
    logic [15:0] res_port;
  } token_t;

  // update broadcast at the end of a scan
  typedef struct packed {
    logic        refresh;
    logic        insert;
    logic [31:0] outside_ip;
  } commit_t;

endpackage

// ===== design/nct_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_cell
// one table entry with its compare logic and a token stage
// ----------------------------------------------------------------------------
module nct_cell #(
  parameter int TABLE_ENTRIES = 64,
  parameter int CELL_INDEX    = 0,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES),
  parameter int RANK_W        = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nct_pkg::query_t       query,
  input  logic [31:0]           idle_timeout_ms,
  input  nct_pkg::token_t       tok_in,
  input  logic [IDX_W-1:0]      hit_idx_in,
  input  logic [RANK_W-1:0]     hit_rank_in,
  input  logic [IDX_W-1:0]      free_idx_in,
  output nct_pkg::token_t       tok_out,
  output logic [IDX_W-1:0]      hit_idx_out,
  output logic [RANK_W-1:0]     hit_rank_out,
  output logic [IDX_W-1:0]      free_idx_out,
  input  nct_pkg::commit_t      commit,
  input  logic [IDX_W-1:0]      commit_idx
);

  localparam logic [IDX_W-1:0]  MY_IDX   = IDX_W'(CELL_INDEX);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(TABLE_ENTRIES);

  logic              valid;
  logic [31:0]       key;
  logic [7:0]        proto;
  logic [31:0]       internal_ip;
  logic [15:0]       internal_port;
  logic [31:0]       outside_ip;
  logic [15:0]       outside_port;
  logic [31:0]       last_used_ms;
  logic [RANK_W-1:0] rank;

  logic              key_match;
  logic              full_match;
  logic              better;
  logic              aged;
  logic [31:0]       age;
  nct_pkg::token_t   tok_next;

  always_comb begin
    age       = query.now_ms - last_used_ms;
    aged      = valid && (age > idle_timeout_ms);
    key_match = valid && (key == query.key) && (query.func == nct_pkg::FUNC_INBOUND);
    full_match = 1'b0;
    if (query.func == nct_pkg::FUNC_INBOUND) begin
      full_match = key_match && (proto == query.proto) && (outside_ip == query.dst_ip)
                   && (outside_port == query.dst_port);
    end else if (query.func == nct_pkg::FUNC_OUTBOUND) begin
      full_match = valid && (key == query.key) && (proto == query.proto)
                   && (internal_ip == query.src_ip) && (internal_port == query.src_port);
    end
    better = full_match && (!tok_in.hit || (rank < hit_rank_in));

    tok_next = tok_in;
    tok_next.bucket = tok_in.bucket | key_match;
    if (better) begin
      tok_next.hit = 1'b1;
      if (query.func == nct_pkg::FUNC_INBOUND) begin
        tok_next.res_ip   = internal_ip;
        tok_next.res_port = internal_port;
      end else begin
        tok_next.res_ip   = outside_ip;
        tok_next.res_port = outside_port;
      end
    end
    if (!valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
    end
    if ((query.func == nct_pkg::FUNC_CLEAN) && aged
        && (tok_in.removed != nct_pkg::REMOVED_MAX)) begin
      tok_next.removed = tok_in.removed + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.bucket     <= tok_next.bucket;
    tok_out.hit        <= tok_next.hit;
    tok_out.free_found <= tok_next.free_found;
    tok_out.removed    <= tok_next.removed;
    tok_out.res_ip     <= tok_next.res_ip;
    tok_out.res_port   <= tok_next.res_port;
    hit_idx_out        <= better ? MY_IDX : hit_idx_in;
    hit_rank_out       <= better ? rank : hit_rank_in;
    free_idx_out       <= (!valid && !tok_in.free_found) ? MY_IDX : free_idx_in;
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      if (tok_in.valid && (query.func == nct_pkg::FUNC_CLEAN) && aged) begin
        valid <= 1'b0;
      end
      if (commit.insert) begin
        if (commit_idx == MY_IDX) begin
          valid <= 1'b1;
          rank  <= '0;
        end else if (valid && (rank < RANK_MAX)) begin
          rank <= rank + RANK_W'(1);
        end
      end
    end
    if (commit.insert && (commit_idx == MY_IDX)) begin
      key           <= query.key;
      proto         <= query.proto;
      internal_ip   <= query.src_ip;
      internal_port <= query.src_port;
      outside_ip    <= commit.outside_ip;
      outside_port  <= query.src_port;
    end
    if ((commit.insert || commit.refresh) && (commit_idx == MY_IDX)) begin
      last_used_ms <= query.now_ms;
    end
  end

endmodule

// ===== design/nat_connection_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_connection_table
// nat connection table with aging, one entry per cell of a search chain
// ----------------------------------------------------------------------------
// an accepted item is registered, its token walks the cell chain one cell per
//   cycle, and the table update and the result register follow at the chain end;
//   a new item is accepted only after the previous result has been taken
// reset: synchronous, clears all entry valid bits, gateway_ip to 0 and
//   idle_timeout_ms to 5000; the table is usable the cycle after reset
module nat_connection_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  // func, proto, src_ip, src_port, dst_ip, dst_port, now_ms (lowest bit up)
  input  logic [143:0] s_tdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // status, new_ip, new_port, removed_count (lowest bit up)
  output logic [63:0]  m_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int RANK_W = $clog2(TABLE_ENTRIES + 1);

  nct_pkg::state_t  state, state_next;
  nct_pkg::query_t  query;
  logic [31:0]      gateway_ip;
  logic [31:0]      idle_timeout_ms;

  // chain links: link 0 is the injection register, link N the chain output
  nct_pkg::token_t   tok    [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]  hit_idx  [0:TABLE_ENTRIES];
  logic [RANK_W-1:0] hit_rank [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]  free_idx [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES:0] tok_valids;

  nct_pkg::commit_t  commit;
  logic [IDX_W-1:0]  commit_idx;
  logic              scan_done;
  logic              accept;

  logic [1:0]  res_status;
  logic [31:0] res_ip;
  logic [15:0] res_port;
  logic [6:0]  res_removed;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == nct_pkg::S_IDLE);
  assign scan_done = (state == nct_pkg::S_SCAN) && tok[TABLE_ENTRIES].valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gateway_ip      <= '0;
      idle_timeout_ms <= nct_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nct_pkg::CFG_GATEWAY_IP: gateway_ip      <= cfg_data;
        nct_pkg::CFG_TIMEOUT:    idle_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // latch the query and build the bucket key from the side that faces out
  always_ff @(posedge clk) begin
    if (accept) begin
      query.func     <= s_tdata[1:0];
      query.proto    <= s_tdata[9:2];
      query.src_ip   <= s_tdata[41:10];
      query.src_port <= s_tdata[57:42];
      query.dst_ip   <= s_tdata[89:58];
      query.dst_port <= s_tdata[105:90];
      query.now_ms   <= s_tdata[137:106];
      if (s_tdata[1:0] == nct_pkg::FUNC_INBOUND) begin
        query.key <= s_tdata[41:10] ^ {16'd0, s_tdata[57:42]};
      end else begin
        query.key <= s_tdata[89:58] ^ {16'd0, s_tdata[105:90]};
      end
    end
  end

  // injection stage: a fresh empty token enters cell 0 the cycle after accept
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= accept;
    end
    tok[0].bucket     <= 1'b0;
    tok[0].hit        <= 1'b0;
    tok[0].free_found <= 1'b0;
    tok[0].removed    <= '0;
    tok[0].res_ip     <= '0;
    tok[0].res_port   <= '0;
    hit_idx[0]        <= '0;
    hit_rank[0]       <= '0;
    free_idx[0]       <= '0;
  end

  generate
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      nct_cell #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CELL_INDEX    (i),
        .IDX_W         (IDX_W),
        .RANK_W        (RANK_W)
      ) u_cell (
        .clk             (clk),
        .rst             (rst),
        .query           (query),
        .idle_timeout_ms (idle_timeout_ms),
        .tok_in          (tok[i]),
        .hit_idx_in      (hit_idx[i]),
        .hit_rank_in     (hit_rank[i]),
        .free_idx_in     (free_idx[i]),
        .tok_out         (tok[i+1]),
        .hit_idx_out     (hit_idx[i+1]),
        .hit_rank_out    (hit_rank[i+1]),
        .free_idx_out    (free_idx[i+1]),
        .commit          (commit),
        .commit_idx      (commit_idx)
      );
    end
    for (genvar j = 0; j <= TABLE_ENTRIES; j++) begin : g_valids
      assign tok_valids[j] = tok[j].valid;
    end
  endgenerate

  // final decision once the token leaves the last cell
  always_comb begin
    res_status   = nct_pkg::ST_OK;
    res_ip       = '0;
    res_port     = '0;
    res_removed  = '0;
    commit       = '0;
    commit.outside_ip = gateway_ip;
    commit_idx   = hit_idx[TABLE_ENTRIES];
    unique case (query.func)
      nct_pkg::FUNC_INBOUND: begin
        if (!tok[TABLE_ENTRIES].bucket) begin
          res_status = nct_pkg::ST_NO_BUCKET;
        end else if (!tok[TABLE_ENTRIES].hit) begin
          res_status = nct_pkg::ST_NO_ENTRY;
        end else begin
          res_ip         = tok[TABLE_ENTRIES].res_ip;
          res_port       = tok[TABLE_ENTRIES].res_port;
          commit.refresh = scan_done;
        end
      end
      nct_pkg::FUNC_OUTBOUND: begin
        if (tok[TABLE_ENTRIES].hit) begin
          res_ip         = tok[TABLE_ENTRIES].res_ip;
          res_port       = tok[TABLE_ENTRIES].res_port;
          commit.refresh = scan_done;
        end else if (tok[TABLE_ENTRIES].free_found) begin
          // new connection goes into the lowest free slot
          res_ip        = gateway_ip;
          res_port      = query.src_port;
          commit.insert = scan_done;
          commit_idx    = free_idx[TABLE_ENTRIES];
        end else begin
          res_status = nct_pkg::ST_FULL;
        end
      end
      nct_pkg::FUNC_CLEAN: begin
        res_removed = tok[TABLE_ENTRIES].removed;
      end
      default: ;
    endcase
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nct_pkg::S_IDLE: if (accept) state_next = nct_pkg::S_SCAN;
      nct_pkg::S_SCAN: if (scan_done) state_next = nct_pkg::S_OUT;
      nct_pkg::S_OUT:  if (m_tready) state_next = nct_pkg::S_IDLE;
      default:         state_next = nct_pkg::S_IDLE;
    endcase
  end

  // output register, held until the result transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (scan_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (scan_done) begin
      m_tdata <= {7'd0, res_removed, res_port, res_ip, res_status};
    end
  end

  // at most one token walks the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valids) <= 1)
    else $error("more than one token in the chain");

  // a result is only offered from the output state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == nct_pkg::S_OUT))
    else $error("result valid outside the output state");

  // table updates only at the end of a scan
  a_commit_scan: assert property (@(posedge clk) disable iff (rst)
    (commit.insert || commit.refresh) |-> scan_done)
    else $error("table update outside scan completion");

  // an accepted item is followed by a token at the chain head
  a_inject: assert property (@(posedge clk) disable iff (rst)
    accept |=> tok[0].valid)
    else $error("accepted item not injected");

endmodule

// ===== bench/tb_nat_connection_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nat_connection_table
// self-checking bench for the nat connection table: a software copy of the
// table predicts status, rewritten address and removed count for every
// transaction, under random bursts, output stalls and register changes
// ----------------------------------------------------------------------------
module tb_nat_connection_table;

  localparam int ENTRIES = 64;
  localparam int LATENCY = ENTRIES + 3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ip;
    logic [15:0] port;
    logic [6:0]  removed;
  } xlat_t;

  logic         clk;
  logic         rst;
  logic [143:0] s_tdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  m_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic         cfg_we;
  logic         cfg_index;
  logic [31:0]  cfg_data;

  nat_connection_table #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the connection table
  logic [31:0] sh_gateway;
  logic [31:0] sh_timeout;
  logic        sh_valid [ENTRIES];
  logic [31:0] sh_key [ENTRIES];
  logic [7:0]  sh_proto [ENTRIES];
  logic [31:0] sh_in_ip [ENTRIES];
  logic [15:0] sh_in_port [ENTRIES];
  logic [31:0] sh_out_ip [ENTRIES];
  logic [15:0] sh_out_port [ENTRIES];
  logic [31:0] sh_last [ENTRIES];
  int unsigned sh_age [ENTRIES];

  xlat_t expected_xlat[$];
  int    errors;
  int    stall_hold;    // long output hold-off, counted down by the stall process
  bit    stall_random;

  // recently used flows, reused so that lookups actually hit
  logic [31:0] flow_ip[$];
  logic [15:0] flow_port[$];
  logic [31:0] flow_rip[$];
  logic [15:0] flow_rport[$];
  logic [7:0]  flow_proto[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("** nat_connection_table: FAILED **");
    $finish;
  end

  function automatic xlat_t predict_translation(logic [1:0] func, logic [7:0] proto,
      logic [31:0] sip, logic [15:0] sport, logic [31:0] dip, logic [15:0] dport,
      logic [31:0] now);
    xlat_t r;
    logic [31:0] key;
    logic bucket;
    int hit;
    int slot;
    int unsigned cnt;
    r = '0;
    hit = -1;
    slot = -1;
    bucket = 1'b0;
    cnt = 0;
    case (func)
      nct_pkg::FUNC_INBOUND: begin
        key = sip ^ {16'h0, sport};
        for (int i = 0; i < ENTRIES; i++) begin
          if (sh_valid[i] && sh_key[i] == key) begin
            bucket = 1'b1;
            if (sh_proto[i] == proto && sh_out_ip[i] == dip && sh_out_port[i] == dport)
              if (hit < 0 || sh_age[i] < sh_age[hit]) hit = i;
          end
        end
        if (!bucket) r.status = nct_pkg::ST_NO_BUCKET;
        else if (hit < 0) r.status = nct_pkg::ST_NO_ENTRY;
        else begin
          sh_last[hit] = now;
          r.ip = sh_in_ip[hit];
          r.port = sh_in_port[hit];
        end
      end
      nct_pkg::FUNC_OUTBOUND: begin
        key = dip ^ {16'h0, dport};
        for (int i = 0; i < ENTRIES; i++) begin
          if (!sh_valid[i]) begin
            if (slot < 0) slot = i;
          end else if (sh_key[i] == key && sh_proto[i] == proto &&
                       sh_in_ip[i] == sip && sh_in_port[i] == sport) begin
            if (hit < 0 || sh_age[i] < sh_age[hit]) hit = i;
          end
        end
        if (hit < 0 && slot < 0) r.status = nct_pkg::ST_FULL;
        else begin
          if (hit < 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (sh_valid[i] && sh_age[i] < ENTRIES) sh_age[i]++;
            hit = slot;
            sh_valid[hit] = 1'b1;
            sh_key[hit] = key;
            sh_proto[hit] = proto;
            sh_in_ip[hit] = sip;
            sh_in_port[hit] = sport;
            sh_out_ip[hit] = sh_gateway;
            sh_out_port[hit] = sport;
            sh_age[hit] = 0;
          end
          sh_last[hit] = now;
          r.ip = sh_out_ip[hit];
          r.port = sh_out_port[hit];
        end
      end
      nct_pkg::FUNC_CLEAN: begin
        for (int i = 0; i < ENTRIES; i++)
          if (sh_valid[i] && (now - sh_last[i]) > sh_timeout) begin
            sh_valid[i] = 1'b0;
            if (cnt < 127) cnt++;
          end
        r.removed = cnt[6:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // one input transaction; drive at falling edge, accepted at the rising edge
  task automatic offer_item(logic [1:0] func, logic [7:0] proto, logic [31:0] sip,
      logic [15:0] sport, logic [31:0] dip, logic [15:0] dport, logic [31:0] now);
    @(negedge clk);
    s_tdata <= {6'd0, now, dport, dip, sport, sip, proto, func};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_xlat.push_back(predict_translation(func, proto, sip, sport, dip, dport, now));
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain_results();
    while (expected_xlat.size() != 0) @(negedge clk);
    idle_cycles(LATENCY + 4);
  endtask

  task automatic write_register(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == nct_pkg::CFG_GATEWAY_IP) sh_gateway = val;
    else sh_timeout = val;
  endtask

  // burst sender: random gap before some items
  task automatic paced_packet(logic [1:0] func, logic [7:0] proto, logic [31:0] sip,
      logic [15:0] sport, logic [31:0] dip, logic [15:0] dport, logic [31:0] now);
    if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 40));
    offer_item(func, proto, sip, sport, dip, dport, now);
  endtask

  // stall pattern on the result side, plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        m_tready <= 1'b0;
        stall_hold--;
      end else if (stall_random) m_tready <= ($urandom_range(0, 3) != 0);
      else m_tready <= 1'b1;
    end
  end

  // result checker
  initial begin
    xlat_t got;
    xlat_t exp_r;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[33:2], m_tdata[49:34], m_tdata[56:50]};
        if (expected_xlat.size() == 0) begin
          $display("%0t unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          exp_r = expected_xlat.pop_front();
          if (got.status !== exp_r.status) begin
            $display("%0t status expected %0d actual %0d", $time, exp_r.status, got.status);
            errors++;
          end
          if (got.ip !== exp_r.ip) begin
            $display("%0t new_ip expected %h actual %h", $time, exp_r.ip, got.ip);
            errors++;
          end
          if (got.port !== exp_r.port) begin
            $display("%0t new_port expected %h actual %h", $time, exp_r.port, got.port);
            errors++;
          end
          if (got.removed !== exp_r.removed) begin
            $display("%0t removed_count expected %0d actual %0d", $time, exp_r.removed,
                     got.removed);
            errors++;
          end
        end
      end
    end
  end

  // corner cases: misses, wrap of the time, func 3, full table
  task automatic test_directed();
    offer_item(nct_pkg::FUNC_INBOUND, 8'd6, 32'h0a000001, 16'd80, 32'h0, 16'd0, 32'd0);
    offer_item(nct_pkg::FUNC_CLEAN, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 32'd0);
    offer_item(nct_pkg::FUNC_OUTBOUND, 8'd0, 32'h0, 16'h0, 32'h0, 16'h0, 32'd0);
    offer_item(nct_pkg::FUNC_OUTBOUND, 8'hff, 32'hffffffff, 16'hffff, 32'hffffffff,
               16'hffff, 32'hffffffff);
    offer_item(nct_pkg::FUNC_OUTBOUND, 8'hff, 32'hffffffff, 16'hffff, 32'hffffffff,
               16'hffff, 32'd5);
    offer_item(nct_pkg::FUNC_INBOUND, 8'hff, 32'hffffffff, 16'hffff, 32'h0, 16'hffff,
               32'd6);
    offer_item(nct_pkg::FUNC_INBOUND, 8'hfe, 32'hffffffff, 16'hffff, 32'h0, 16'hffff,
               32'd6);
    offer_item(nct_pkg::FUNC_INBOUND, 8'h0, 32'h0, 16'h0, 32'h0, 16'h0, 32'd6);
    offer_item(nct_pkg::FUNC_NOP, 8'haa, 32'h55555555, 16'haaaa, 32'haaaaaaaa, 16'h5555,
               32'h12345678);
    // two entries share a bucket, the newer wins on inbound
    offer_item(nct_pkg::FUNC_OUTBOUND, 8'd17, 32'hc0a80001, 16'd1000, 32'h08080808,
               16'd53, 32'd10);
    offer_item(nct_pkg::FUNC_OUTBOUND, 8'd17, 32'hc0a80002, 16'd1000, 32'h08080808,
               16'd53, 32'd11);
    offer_item(nct_pkg::FUNC_INBOUND, 8'd17, 32'h08080808, 16'd53, 32'h0, 16'd1000,
               32'd12);
    // clean across time wrap keeps fresh entries, then sweeps all
    offer_item(nct_pkg::FUNC_CLEAN, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 32'd4000);
    offer_item(nct_pkg::FUNC_CLEAN, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 32'h80000000);
    // fill the table then overflow it
    for (int i = 0; i < ENTRIES; i++)
      offer_item(nct_pkg::FUNC_OUTBOUND, 8'd6, 32'h0a000000 + i, 16'd2000, 32'h01010101,
                 16'd443, 32'd1);
    offer_item(nct_pkg::FUNC_OUTBOUND, 8'd6, 32'h0b000000, 16'd2000, 32'h01010101,
               16'd443, 32'd2);
    offer_item(nct_pkg::FUNC_CLEAN, 8'd0, 32'h0, 16'd0, 32'h0, 16'd0, 32'd100000);
    drain_results();
  endtask

  task automatic random_packet();
    logic [1:0]  func;
    logic [7:0]  proto;
    logic [31:0] rip;
    logic [15:0] rport;
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] now;
    int          pick;
    int          sel;
    func = 2'($urandom_range(0, 9) < 4 ? nct_pkg::FUNC_OUTBOUND : nct_pkg::FUNC_INBOUND);
    sel = $urandom_range(0, 29);
    if (sel == 0) func = nct_pkg::FUNC_CLEAN;
    else if (sel == 1) func = nct_pkg::FUNC_NOP;
    now = 32'($urandom_range(0, 20000));
    if (flow_ip.size() != 0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, flow_ip.size() - 1);
      rip = flow_rip[pick];
      rport = flow_rport[pick];
      lip = flow_ip[pick];
      lport = flow_port[pick];
      proto = flow_proto[pick];
    end else begin
      rip = $urandom;
      rport = 16'($urandom);
      lip = $urandom;
      lport = 16'($urandom);
      proto = 8'($urandom);
      flow_rip.push_back(rip);
      flow_rport.push_back(rport);
      flow_ip.push_back(lip);
      flow_port.push_back(lport);
      flow_proto.push_back(proto);
      if (flow_ip.size() > 80) begin
        void'(flow_rip.pop_front());
        void'(flow_rport.pop_front());
        void'(flow_ip.pop_front());
        void'(flow_port.pop_front());
        void'(flow_proto.pop_front());
      end
    end
    if (func == nct_pkg::FUNC_OUTBOUND)
      paced_packet(func, proto, lip, lport, rip, rport, now);
    else if ($urandom_range(0, 5) == 0)
      // noise inbound: random fields
      paced_packet(func, 8'($urandom), $urandom, 16'($urandom), $urandom, 16'($urandom), now);
    else
      // replies addressed to the gateway; port mismatch now and then
      paced_packet(func, proto, rip, rport, sh_gateway,
                   ($urandom_range(0, 7) == 0) ? 16'($urandom) : lport, now);
  endtask

  task automatic test_random_phase(int n, logic [31:0] gw, logic [31:0] tmo);
    write_register(nct_pkg::CFG_GATEWAY_IP, gw);
    write_register(nct_pkg::CFG_TIMEOUT, tmo);
    for (int i = 0; i < n; i++) random_packet();
    drain_results();
  endtask

  // long output hold-off while the sender keeps pushing, then a full pause
  task automatic test_backpressure();
    stall_hold = 400;
    for (int i = 0; i < 12; i++) random_packet();
    while (expected_xlat.size() != 0) @(negedge clk);
    for (int i = 0; i < 12; i++) random_packet();
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = nct_pkg::CFG_GATEWAY_IP;
    cfg_data = '0;
    errors = 0;
    stall_hold = 0;
    stall_random = 1'b0;
    sh_gateway = '0;
    sh_timeout = nct_pkg::TIMEOUT_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_age[i] = 0;
      sh_last[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    stall_random = 1'b1;
    test_random_phase(400, 32'hc0a80101, 32'd5000);
    test_backpressure();
    test_random_phase(350, 32'hffffffff, 32'hffffffff);
    stall_random = 1'b0;
    test_random_phase(300, 32'h00000000, 32'd0);
    stall_random = 1'b1;
    test_random_phase(350, 32'h7f000001, 32'd3000);
    if (errors == 0) $display("** nat_connection_table: PASSED **");
    else $display("** nat_connection_table: FAILED **");
    $finish;
  end

endmodule
